// File: design/apbp_pkg.sv
// Shared types and constants for the alpha blend pixel pack unit.
`timescale 1ns / 1ps
package apbp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_BPP     = 3'd0,
    CFG_RED_BITS    = 3'd1,
    CFG_GREEN_BITS  = 3'd2,
    CFG_BLUE_BITS   = 3'd3,
    CFG_RED_SHIFT   = 3'd4,
    CFG_GREEN_SHIFT = 3'd5,
    CFG_BLUE_SHIFT  = 3'd6
  } cfg_idx_e;

  localparam logic [2:0] BPP_RGB  = 3'd3;
  localparam logic [2:0] BPP_RGBA = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef logic [7:0]  chan_t;
  typedef logic [14:0] quot_t;
  typedef logic [22:0] prod_t;

  typedef struct packed {
    logic mul_en;
    logic div_en;
  } scale_en_t;

endpackage

// File: design/apbp_in_if.sv
// Input channel: source pixel and destination pixel word.
`timescale 1ns / 1ps
interface apbp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  src_blue;
  logic [7:0]  src_green;
  logic [7:0]  src_red;
  logic [7:0]  src_alpha;
  logic [31:0] background_pixel;

  modport source (
    output valid, src_blue, src_green, src_red, src_alpha, background_pixel,
    input  ready
  );
  modport sink (
    input  valid, src_blue, src_green, src_red, src_alpha, background_pixel,
    output ready
  );
endinterface

// File: design/apbp_out_if.sv
// Output channel: packed framebuffer color word.
`timescale 1ns / 1ps
interface apbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_color;

  modport source (
    output valid, packed_color,
    input  ready
  );
  modport sink (
    input  valid, packed_color,
    output ready
  );
endinterface

// File: design/alpha_blend_pixel_pack_unit.sv
// Top level: alpha blend of a source pixel over the frame and packing to framebuffer format.
`timescale 1ns / 1ps
// Takes one pixel per clock when the output is not stalled and returns its
// packed color through a four-stage pipeline (blend, channel multiply, divide
// by 255, shift and merge); each stage holds its word under back-pressure,
// and empty stages still accept. Pixels with alpha 0 in 4-byte mode, or with
// a source size other than 3 or 4, produce no output word. The user must
// write configuration only while idle; the block does not enforce it.
module alpha_blend_pixel_pack_unit
  import apbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  apbp_in_if.sink             pix_in,
  apbp_out_if.source          pix_out
);

  logic [2:0] src_bpp_q;
  logic [3:0] red_bits_q, green_bits_q, blue_bits_q;
  logic [4:0] red_shift_q, green_shift_q, blue_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_bpp_q     <= BPP_RGBA;
      red_bits_q    <= 4'd8;
      green_bits_q  <= 4'd8;
      blue_bits_q   <= 4'd8;
      red_shift_q   <= 5'd16;
      green_shift_q <= 5'd8;
      blue_shift_q  <= 5'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SRC_BPP:     src_bpp_q     <= cfg_data_i[2:0];
        CFG_RED_BITS:    red_bits_q    <= cfg_data_i[3:0];
        CFG_GREEN_BITS:  green_bits_q  <= cfg_data_i[3:0];
        CFG_BLUE_BITS:   blue_bits_q   <= cfg_data_i[3:0];
        CFG_RED_SHIFT:   red_shift_q   <= cfg_data_i;
        CFG_GREEN_SHIFT: green_shift_q <= cfg_data_i;
        CFG_BLUE_SHIFT:  blue_shift_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic chan_t blend(input chan_t fg, input chan_t bg, input chan_t a);
    logic [8:0]  w;
    logic [16:0] mix;
    w   = {1'b0, a} + 9'd1;
    mix = ({9'd0, fg} * {8'd0, w}) + ({9'd0, bg} * {9'd0, ~a});
    return mix[15:8];
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc, keep, pass;
  chan_t r1_q, g1_q, b1_q;
  chan_t r1_d, g1_d, b1_d;
  quot_t rq, gq, bq;
  logic [31:0] color_d, color_q;
  scale_en_t scale_en;

  assign rdy4 = !v4_q || pix_out.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign pix_in.ready = rdy1;
  assign in_acc       = pix_in.valid && rdy1;

  assign pass = (src_bpp_q == BPP_RGB) || (pix_in.src_alpha == ALPHA_OPAQUE);
  assign keep = (src_bpp_q == BPP_RGB) ||
                ((src_bpp_q == BPP_RGBA) && (pix_in.src_alpha != ALPHA_CLEAR));

  always_comb begin
    if (pass) begin
      r1_d = pix_in.src_red;
      g1_d = pix_in.src_green;
      b1_d = pix_in.src_blue;
    end else begin
      r1_d = blend(pix_in.src_red,   pix_in.background_pixel[23:16], pix_in.src_alpha);
      g1_d = blend(pix_in.src_green, pix_in.background_pixel[15:8],  pix_in.src_alpha);
      b1_d = blend(pix_in.src_blue,  pix_in.background_pixel[7:0],   pix_in.src_alpha);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_in.valid && keep;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r1_q <= r1_d;
      g1_q <= g1_d;
      b1_q <= b1_d;
    end
    if (rdy4 && v3_q) begin
      color_q <= color_d;
    end
  end

  assign scale_en.mul_en = rdy2 && v1_q;
  assign scale_en.div_en = rdy3 && v2_q;

  apbp_chan_scale u_scale_r (
    .clk_i  (clk_i),
    .en_i   (scale_en),
    .chan_i (r1_q),
    .bits_i (red_bits_q),
    .quot_o (rq)
  );

  apbp_chan_scale u_scale_g (
    .clk_i  (clk_i),
    .en_i   (scale_en),
    .chan_i (g1_q),
    .bits_i (green_bits_q),
    .quot_o (gq)
  );

  apbp_chan_scale u_scale_b (
    .clk_i  (clk_i),
    .en_i   (scale_en),
    .chan_i (b1_q),
    .bits_i (blue_bits_q),
    .quot_o (bq)
  );

  assign color_d = ({17'd0, rq} << red_shift_q)
                 | ({17'd0, gq} << green_shift_q)
                 | ({17'd0, bq} << blue_shift_q);

  assign pix_out.valid        = v4_q;
  assign pix_out.packed_color = color_q;

  a_bad_bpp_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && src_bpp_q != BPP_RGB && src_bpp_q != BPP_RGBA) |=> !v1_q)
    else $error("word with unsupported source size entered pipeline");

  a_clear_alpha_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && src_bpp_q == BPP_RGBA && pix_in.src_alpha == ALPHA_CLEAR) |=> !v1_q)
    else $error("transparent pixel entered pipeline");

  a_rgb_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && src_bpp_q == BPP_RGB) |=>
      (v1_q && r1_q == $past(pix_in.src_red) && g1_q == $past(pix_in.src_green) &&
       b1_q == $past(pix_in.src_blue)))
    else $error("opaque source color altered in blend stage");

  a_stage3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> v3_q)
    else $error("stalled word lost in divide stage");

endmodule

// File: design/apbp_chan_scale.sv
// Two-stage channel rescale: c * (2^bits - 1), then divide by 255.
`timescale 1ns / 1ps
module apbp_chan_scale
  import apbp_pkg::*;
(
  input  logic      clk_i,
  input  scale_en_t en_i,
  input  chan_t     chan_i,
  input  logic [3:0] bits_i,
  output quot_t     quot_o
);

  logic [14:0] maxv;
  prod_t       prod_d, prod_q;
  logic [23:0] sum;
  logic [15:0] q_est;
  logic [23:0] rem;
  quot_t       quot_d, quot_q;

  assign maxv   = 15'((16'd1 << bits_i) - 16'd1);
  assign prod_d = {15'd0, chan_i} * {8'd0, maxv};

  // estimate is exact or one low; remainder check fixes it
  assign sum    = {1'b0, prod_q} + {9'd0, prod_q[22:8]} + {17'd0, prod_q[22:16]};
  assign q_est  = sum[23:8];
  assign rem    = {1'b0, prod_q} - (({q_est, 8'd0}) - {8'd0, q_est});
  assign quot_d = (rem >= 24'd255) ? quot_t'(q_est + 16'd1) : quot_t'(q_est);

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (en_i.div_en) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule
